// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the scheduler core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RFS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("rfs assertion failed");

// An implication checked in the same cycle.
`define RFS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rfs assertion failed");

`endif

// ===== rtl/core/rfs_pkg.sv =====
package rfs_pkg;

    localparam int MAX_ROWS  = 4096;
    localparam int ROW_W     = 12;
    localparam int CNT_W     = 13;
    localparam int POS_W     = 15;
    localparam int WORD_W    = 64;
    localparam int BIT_W     = 6;
    localparam int NUM_WORDS = MAX_ROWS / WORD_W;
    localparam int WADDR_W   = 6;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_FOCUS     = 3'd1,
        OP_FOCUS_NBR = 3'd2,
        OP_PUT_BACK  = 3'd3,
        OP_NEXT      = 3'd4
    } op_t;

    // Row listed at position p of the priority window.
    function automatic logic [ROW_W-1:0] window_entry(
        input logic [POS_W-1:0] p,
        input logic [ROW_W-1:0] first,
        input logic [ROW_W-1:0] last,
        input logic [ROW_W-1:0] ahead_end
    );
        logic [POS_W-1:0] vp;
        logic [POS_W-1:0] ah;
        logic [POS_W-1:0] q;
        vp = POS_W'(last) - POS_W'(first) + POS_W'(1);
        ah = (ahead_end > last) ? POS_W'(ahead_end - last) : '0;
        if (p < vp) begin
            return first + p[ROW_W-1:0];
        end else if (p < vp + ah) begin
            q = p - vp;
            return last + ROW_W'(1) + q[ROW_W-1:0];
        end else begin
            q = p - vp - ah;
            return first - ROW_W'(1) - q[ROW_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/rfs_ram.sv =====
module rfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/rfs_wscan.sv =====
module rfs_wscan (
    input  logic [rfs_pkg::WORD_W-1:0] taken,
    input  logic                       use_lo,
    input  logic [rfs_pkg::BIT_W-1:0]  lo,
    input  logic                       use_hi,
    input  logic [rfs_pkg::BIT_W-1:0]  hi,
    input  logic [rfs_pkg::BIT_W:0]    lim,
    output logic                       hit,
    output logic [rfs_pkg::BIT_W-1:0]  idx
);
    import rfs_pkg::*;

    logic [WORD_W-1:0] free;

    // A bit is a candidate when it is free and lies inside the scan window.
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            free[b] = !taken[b]
                && (!use_lo || (BIT_W'(b) >= lo))
                && (!use_hi || (BIT_W'(b) < hi))
                && ((BIT_W+1)'(b) < lim);
        end
    end

    always_comb begin
        idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free[b]) begin
                idx = BIT_W'(b);
            end
        end
    end

    assign hit = |free;
endmodule

// ===== rtl/core/focused_row_sweep_scheduler_core.sv =====
// Clear writes every bitmap word in turn; focus with neighbours clamps in S_FOC and
// sets the window in S_FOC2; put-back reads in S_PRD and checks in S_PCK. Next checks
// each window entry in range (skipping those beyond the sweep), leaves a spent window,
// scans 64-row words (at most 65), then loads the output. One item is taken at a time.
// Reset (aresetn low, synchronous) zeroes the control state and starts a clearing
// pass that writes the bitmap RAM; no item is accepted until it finishes.
`include "assert_macros.svh"

module focused_row_sweep_scheduler_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: row_count register.
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // first_row[11:0], last_row[23:12], row[35:24], zero pad
    input  logic [2:0]  s_tuser,   // op[2:0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // served_row[11:0], found[12], zero pad
    output logic        m_tuser    // is_foreground[0]
);
    import rfs_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_CLR  = 11'b000_0000_0010,
        S_FOC  = 11'b000_0000_0100,
        S_FOC2 = 11'b000_0000_1000,
        S_WRD  = 11'b000_0001_0000,
        S_WCK  = 11'b000_0010_0000,
        S_SRD  = 11'b000_0100_0000,
        S_SCK  = 11'b000_1000_0000,
        S_PRD  = 11'b001_0000_0000,
        S_PCK  = 11'b010_0000_0000,
        S_RES  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   row_count_reg;
    logic [CNT_W-1:0]   active_reg, active_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [ROW_W-1:0]   cursor_reg, cursor_next;
    logic [ROW_W-1:0]   cat_reg, cat_next;
    logic [ROW_W-1:0]   wf_reg, wf_next;
    logic [ROW_W-1:0]   wl_reg, wl_next;
    logic [ROW_W-1:0]   wae_reg, wae_next;
    logic [ROW_W-1:0]   wbe_reg, wbe_next;
    logic [POS_W-1:0]   wlen_reg, wlen_next;
    logic [POS_W-1:0]   wpos_reg, wpos_next;
    logic [WADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ROW_W-1:0]   fr_reg, fr_next;
    logic [ROW_W-1:0]   lr_reg, lr_next;
    logic [ROW_W-1:0]   cand_reg, cand_next;
    logic [WADDR_W-1:0] word_reg, word_next;
    logic [WADDR_W:0]   k_reg, k_next;
    logic [ROW_W-1:0]   res_row_reg, res_row_next;
    logic               res_found_reg, res_found_next;
    logic               res_fg_reg, res_fg_next;
    logic               m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]   m_row_reg, m_row_next;
    logic               m_found_reg, m_found_next;
    logic               m_fg_reg, m_fg_next;

    // Bitmap RAM: one 64-bit word per 64 rows.
    logic               ram_we;
    logic [WADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;

    rfs_ram #(
        .WIDTH(WORD_W),
        .DEPTH(NUM_WORDS)
    ) u_map (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Input fields.
    logic [ROW_W-1:0] in_first, in_last, in_row;
    op_t              in_op;
    assign in_first = s_tdata[11:0];
    assign in_last  = s_tdata[23:12];
    assign in_row   = s_tdata[35:24];
    assign in_op    = op_t'(s_tuser);

    logic [CNT_W-1:0] rows_m1;
    assign rows_m1 = active_reg - CNT_W'(1);

    // Words spanned by the sweep, and valid bits in its final word.
    logic [WADDR_W:0] num_words;
    logic [BIT_W:0]   last_lim;
    logic             is_last_word;
    logic [CNT_W-1:0] rows_up;
    assign rows_up      = active_reg + CNT_W'(WORD_W - 1);
    assign num_words    = rows_up[CNT_W-1:BIT_W];
    assign last_lim     = (active_reg[BIT_W-1:0] == '0) ? (BIT_W+1)'(WORD_W)
                                                         : {1'b0, active_reg[BIT_W-1:0]};
    assign is_last_word = ({1'b0, word_reg} == num_words - (WADDR_W+1)'(1));

    // Word scanner for the cursor sweep. The first word is masked below the
    // cursor; the wrapped revisit of that word is masked at and above it.
    logic             sc_hit;
    logic [BIT_W-1:0] sc_idx;

    rfs_wscan u_scan (
        .taken (ram_rdata),
        .use_lo(k_reg == '0),
        .lo    (cursor_reg[BIT_W-1:0]),
        .use_hi(k_reg == num_words),
        .hi    (cursor_reg[BIT_W-1:0]),
        .lim   (is_last_word ? last_lim : (BIT_W+1)'(WORD_W)),
        .hit   (sc_hit),
        .idx   (sc_idx)
    );

    // Window entries at the current position and the one before it.
    logic [ROW_W-1:0] win_row, prev_row;
    assign win_row  = window_entry(wpos_reg, wf_reg, wl_reg, wae_reg);
    assign prev_row = window_entry(wpos_reg - POS_W'(1), wf_reg, wl_reg, wae_reg);

    // Focus-with-neighbours arithmetic, from the clamped visible span.
    logic [CNT_W-1:0]   vp;
    logic [CNT_W:0]     adj;
    logic [CNT_W+1:0]   ahead_sum;
    logic [ROW_W-1:0]   ae_calc, be_calc;
    assign vp        = CNT_W'(wl_reg) - CNT_W'(wf_reg) + CNT_W'(1);
    assign adj       = {vp, 1'b0};
    assign ahead_sum = (CNT_W+2)'(wl_reg) + (CNT_W+2)'(adj);
    assign ae_calc   = (ahead_sum > (CNT_W+2)'(rows_m1)) ? rows_m1[ROW_W-1:0]
                                                         : ahead_sum[ROW_W-1:0];
    assign be_calc   = ((CNT_W+1)'(wf_reg) > adj) ? (wf_reg - adj[ROW_W-1:0]) : '0;

    // The row just found by the scan and the cursor after taking a row.
    logic [ROW_W-1:0] scan_row, take_row, take_cursor;
    assign scan_row    = {word_reg, sc_idx};
    assign take_row    = state_reg == S_WCK ? cand_reg : scan_row;
    assign take_cursor = (CNT_W'(take_row) + CNT_W'(1) == active_reg) ? '0
                                                                      : take_row + ROW_W'(1);

    logic handshake;
    assign handshake = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        active_next    = active_reg;
        left_next      = left_reg;
        cursor_next    = cursor_reg;
        cat_next       = cat_reg;
        wf_next        = wf_reg;
        wl_next        = wl_reg;
        wae_next       = wae_reg;
        wbe_next       = wbe_reg;
        wlen_next      = wlen_reg;
        wpos_next      = wpos_reg;
        clr_cnt_next   = clr_cnt_reg;
        fr_next        = fr_reg;
        lr_next        = lr_reg;
        cand_next      = cand_reg;
        word_next      = word_reg;
        k_next         = k_reg;
        res_row_next   = res_row_reg;
        res_found_next = res_found_reg;
        res_fg_next    = res_fg_reg;
        ram_we         = 1'b0;
        ram_waddr      = cand_reg[ROW_W-1:BIT_W];
        ram_wdata      = ram_rdata;
        ram_raddr      = cand_reg[ROW_W-1:BIT_W];

        case (state_reg)
            S_IDLE: begin
                if (handshake) begin
                    case (in_op)
                        OP_CLEAR: begin
                            active_next  = (row_count_reg > CNT_W'(MAX_ROWS)) ?
                                           CNT_W'(MAX_ROWS) : row_count_reg;
                            left_next    = active_next;
                            cursor_next  = '0;
                            cat_next     = '0;
                            wf_next      = '0;
                            wl_next      = '0;
                            wae_next     = '0;
                            wbe_next     = '0;
                            wlen_next    = '0;
                            wpos_next    = '0;
                            clr_cnt_next = '0;
                            state_next   = S_CLR;
                        end
                        OP_FOCUS: begin
                            if (active_reg != '0) begin
                                wlen_next   = '0;
                                wpos_next   = '0;
                                cursor_next = (CNT_W'(in_first) > rows_m1) ?
                                              rows_m1[ROW_W-1:0] : in_first;
                            end
                        end
                        OP_FOCUS_NBR: begin
                            if (active_reg != '0) begin
                                fr_next    = in_first;
                                lr_next    = in_last;
                                state_next = S_FOC;
                            end
                        end
                        OP_PUT_BACK: begin
                            if (CNT_W'(in_row) < active_reg) begin
                                cand_next  = in_row;
                                state_next = S_PRD;
                            end
                        end
                        OP_NEXT: begin
                            if (active_reg == '0 || left_reg == '0) begin
                                res_row_next   = '0;
                                res_found_next = 1'b0;
                                res_fg_next    = 1'b0;
                                state_next     = S_RES;
                            end else begin
                                state_next = S_WRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + WADDR_W'(1);
                if (clr_cnt_reg == WADDR_W'(NUM_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_FOC: begin
                // Clamp first to the row range and last between first and end.
                wf_next = (CNT_W'(fr_reg) > rows_m1) ? rows_m1[ROW_W-1:0] : fr_reg;
                if (lr_reg < wf_next) begin
                    wl_next = wf_next;
                end else if (CNT_W'(lr_reg) > rows_m1) begin
                    wl_next = rows_m1[ROW_W-1:0];
                end else begin
                    wl_next = lr_reg;
                end
                state_next = S_FOC2;
            end
            S_FOC2: begin
                wae_next    = ae_calc;
                wbe_next    = be_calc;
                wlen_next   = POS_W'(vp) + POS_W'(ae_calc - wl_reg) + POS_W'(wf_reg - be_calc);
                wpos_next   = '0;
                cursor_next = wf_reg;
                state_next  = S_IDLE;
            end
            S_WRD: begin
                if (wpos_reg < wlen_reg) begin
                    wpos_next = wpos_reg + POS_W'(1);
                    cand_next = win_row;
                    ram_raddr = win_row[ROW_W-1:BIT_W];
                    if (CNT_W'(win_row) < active_reg) begin
                        state_next = S_WCK;
                    end
                end else begin
                    // Window spent: sweep the bitmap from the cursor word.
                    word_next  = cursor_reg[ROW_W-1:BIT_W];
                    k_next     = '0;
                    state_next = S_SRD;
                end
            end
            S_WCK: begin
                if (ram_rdata[cand_reg[BIT_W-1:0]]) begin
                    state_next = S_WRD;
                end else begin
                    ram_we         = 1'b1;
                    ram_wdata[cand_reg[BIT_W-1:0]] = 1'b1;
                    left_next      = left_reg - CNT_W'(1);
                    cursor_next    = take_cursor;
                    cat_next       = take_cursor;
                    res_row_next   = cand_reg;
                    res_found_next = 1'b1;
                    res_fg_next    = 1'b1;
                    state_next     = S_RES;
                end
            end
            S_SRD: begin
                ram_raddr  = word_reg;
                state_next = S_SCK;
            end
            S_SCK: begin
                if (sc_hit) begin
                    ram_we         = 1'b1;
                    ram_waddr      = word_reg;
                    ram_wdata[sc_idx] = 1'b1;
                    left_next      = left_reg - CNT_W'(1);
                    cursor_next    = take_cursor;
                    cat_next       = take_cursor;
                    res_row_next   = scan_row;
                    res_found_next = 1'b1;
                    res_fg_next    = 1'b0;
                    state_next     = S_RES;
                end else if (k_reg == num_words) begin
                    res_row_next   = '0;
                    res_found_next = 1'b0;
                    res_fg_next    = 1'b0;
                    state_next     = S_RES;
                end else begin
                    k_next     = k_reg + (WADDR_W+1)'(1);
                    word_next  = is_last_word ? '0 : word_reg + WADDR_W'(1);
                    state_next = S_SRD;
                end
            end
            S_PRD: begin
                state_next = S_PCK;
            end
            S_PCK: begin
                if (ram_rdata[cand_reg[BIT_W-1:0]]) begin
                    ram_we    = 1'b1;
                    ram_wdata[cand_reg[BIT_W-1:0]] = 1'b0;
                    left_next = left_reg + CNT_W'(1);
                    // Rewind only when no refocus happened since the take.
                    if (cursor_reg == cat_reg) begin
                        cursor_next = cand_reg;
                        if (wpos_reg != '0 && wpos_reg <= wlen_reg && prev_row == cand_reg) begin
                            wpos_next = wpos_reg - POS_W'(1);
                        end
                    end
                end
                state_next = S_IDLE;
            end
            S_RES: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: loaded from the result holding register when free.
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_row_next   = m_row_reg;
        m_found_next = m_found_reg;
        m_fg_next    = m_fg_reg;
        if (state_reg == S_RES && (!m_valid_reg || m_tready)) begin
            m_valid_next = 1'b1;
            m_row_next   = res_row_reg;
            m_found_next = res_found_reg;
            m_fg_next    = res_fg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            row_count_reg <= '0;
            active_reg    <= '0;
            left_reg      <= '0;
            cursor_reg    <= '0;
            cat_reg       <= '0;
            wf_reg        <= '0;
            wl_reg        <= '0;
            wae_reg       <= '0;
            wbe_reg       <= '0;
            wlen_reg      <= '0;
            wpos_reg      <= '0;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_we) begin
                row_count_reg <= cfg_wdata;
            end
            active_reg  <= active_next;
            left_reg    <= left_next;
            cursor_reg  <= cursor_next;
            cat_reg     <= cat_next;
            wf_reg      <= wf_next;
            wl_reg      <= wl_next;
            wae_reg     <= wae_next;
            wbe_reg     <= wbe_next;
            wlen_reg    <= wlen_next;
            wpos_reg    <= wpos_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fr_reg        <= fr_next;
        lr_reg        <= lr_next;
        cand_reg      <= cand_next;
        word_reg      <= word_next;
        k_reg         <= k_next;
        res_row_reg   <= res_row_next;
        res_found_reg <= res_found_next;
        res_fg_reg    <= res_fg_next;
        m_row_reg     <= m_row_next;
        m_found_reg   <= m_found_next;
        m_fg_reg      <= m_fg_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_found_reg, m_row_reg};
    assign m_tuser  = m_fg_reg;

    // The count of rows still to serve never exceeds the sweep size.
    `RFS_ASSERT(a_left_bound, aclk, aresetn, left_reg <= active_reg)
    // The cursor always points inside the sweep when there is one.
    `RFS_ASSERT(a_cursor_range, aclk, aresetn,
                (active_reg == '0) || (CNT_W'(cursor_reg) < active_reg))
    // The bitmap is never written while the block waits for an item.
    `RFS_ASSERT_IMP(a_idle_no_write, aclk, aresetn, state_reg == S_IDLE, !ram_we)

endmodule
